// ===== hw/rtl/asfo_pkg.sv =====
// Package for the audio sample FIFO with overwrite of the oldest sample.
// Holds the field widths and the operation codes; depends on nothing else.
`default_nettype none

package asfo_pkg;

   // Widths of the transaction fields.
   localparam int unsigned OP_W     = 2;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned DEPTH_W  = 11;
   localparam int unsigned CNT_W    = 32;

   // Operation codes carried in the op field. The fourth code does nothing.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_FLUSH = 2'd2
   } op_type;

endpackage

`default_nettype wire

// ===== hw/rtl/asfo_req_if.sv =====
// Request channel of the audio sample FIFO: valid, ready and the request payload.
// Depends on asfo_pkg for the field widths.
`default_nettype none

interface asfo_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [asfo_pkg::OP_W-1:0]        op;
   logic signed [asfo_pkg::SAMPLE_W-1:0]    sample_in;

   modport source (output valid, output op, output sample_in, input ready);
   modport sink   (input valid, input op, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/asfo_rsp_if.sv =====
// Response channel of the audio sample FIFO: valid, ready and the response payload.
// Depends on asfo_pkg for the field widths.
`default_nettype none

interface asfo_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [asfo_pkg::SAMPLE_W-1:0]    sample_out;
   logic                                    underrun;
   logic                                    overrun;
   logic        [asfo_pkg::DEPTH_W-1:0]     depth;
   logic        [asfo_pkg::CNT_W-1:0]       overrun_total;
   logic        [asfo_pkg::CNT_W-1:0]       underrun_total;
   logic        [asfo_pkg::CNT_W-1:0]       pushed_total;
   logic        [asfo_pkg::CNT_W-1:0]       pulled_total;

   modport source (output valid, output sample_out, output underrun, output overrun,
                   output depth, output overrun_total, output underrun_total,
                   output pushed_total, output pulled_total, input ready);
   modport sink   (input valid, input sample_out, input underrun, input overrun,
                   input depth, input overrun_total, input underrun_total,
                   input pushed_total, input pulled_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/audio_sample_fifo_overwrite_unit.sv =====
// Audio sample ring buffer with overwrite of the oldest sample when full.
// One request transaction gives one response transaction. In its acceptance cycle the
// request updates pointers and counters, issues the sample memory access and parks its
// result fields in a pending stage. Once the response register is free or being taken,
// the registered memory read data is merged with them into that register, which drives
// the response channel. A new request is taken every cycle while the response side
// keeps up. The pending stage lets one request be accepted while a finished response
// still waits; after that the input stalls until the response side takes a transaction.
// Each transaction makes at most one memory access, one read or one write, so the
// memory never limits the rate. The memory holds QUEUE_DEPTH samples and needs no
// clearing pass after reset, since a pull only reads entries that a push has written.
// Depends on asfo_pkg, asfo_req_if and asfo_rsp_if.
`default_nettype none

module audio_sample_fifo_overwrite_unit #(
   parameter int unsigned QUEUE_DEPTH = 1024
) (
   input  wire         clock,
   input  wire         reset,
   asfo_req_if.sink    req_if,
   asfo_rsp_if.source  rsp_if
);
   import asfo_pkg::*;

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   // Pending stage contents, waiting for the memory read data.
   typedef struct packed {
      logic               hit;
      logic               underrun;
      logic               overrun;
      logic [DEPTH_W-1:0] depth;
      logic [CNT_W-1:0]   ovr_total;
      logic [CNT_W-1:0]   und_total;
      logic [CNT_W-1:0]   push_total;
      logic [CNT_W-1:0]   pull_total;
   } pend_type;

   // Sample memory and its registered read data.
   logic [SAMPLE_W-1:0] sample_mem [QUEUE_DEPTH];
   logic [SAMPLE_W-1:0] mem_rdata_ff;
   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_waddr;

   // Queue state and totals.
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0] ovr_cnt_ff, ovr_cnt_in;
   logic [CNT_W-1:0] und_cnt_ff, und_cnt_in;
   logic [CNT_W-1:0] push_cnt_ff, push_cnt_in;
   logic [CNT_W-1:0] pull_cnt_ff, pull_cnt_in;

   // Pending stage and response register.
   logic                pend_valid_ff, pend_valid_in;
   pend_type            pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pend_type            rsp_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff;

   logic          req_fire;
   logic          pend_move;
   logic          full;
   logic          empty;
   logic [AW-1:0] rd_ptr_inc;
   logic [AW-1:0] push_ptr;
   logic [AW-1:0] push_base;
   logic [AW:0]   slot_sum;
   logic          hit;
   logic          und_flag;
   logic          ovr_flag;

   // Handshake between the stages.
   assign pend_move    = pend_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !pend_valid_ff || pend_move;
   assign req_fire     = req_if.valid && req_if.ready;

   // Pointer arithmetic; the slot sum stays below twice the depth.
   assign full       = (fill_ff >= CW'(QUEUE_DEPTH));
   assign empty      = (fill_ff == '0);
   assign rd_ptr_inc = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign push_ptr   = full ? rd_ptr_inc : rd_ptr_ff;
   assign push_base  = full ? AW'(QUEUE_DEPTH - 1) : fill_ff[AW-1:0];
   assign slot_sum   = {1'b0, push_ptr} + {1'b0, push_base};
   assign mem_waddr  = (slot_sum >= (AW+1)'(QUEUE_DEPTH))
                       ? AW'(slot_sum - (AW+1)'(QUEUE_DEPTH)) : slot_sum[AW-1:0];

   // Next state of the queue for an accepted transaction.
   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      fill_in     = fill_ff;
      ovr_cnt_in  = ovr_cnt_ff;
      und_cnt_in  = und_cnt_ff;
      push_cnt_in = push_cnt_ff;
      pull_cnt_in = pull_cnt_ff;
      hit         = 1'b0;
      und_flag    = 1'b0;
      ovr_flag    = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      if (req_fire) begin
         case (op_type'(req_if.op))
            OP_PUSH: begin
               if (full) begin
                  ovr_cnt_in = ovr_cnt_ff + 1'b1;
                  ovr_flag   = 1'b1;
               end
               rd_ptr_in   = push_ptr;
               fill_in     = CW'(push_base) + 1'b1;
               push_cnt_in = push_cnt_ff + 1'b1;
               mem_we      = 1'b1;
            end
            OP_PULL: begin
               if (empty) begin
                  und_cnt_in = und_cnt_ff + 1'b1;
                  und_flag   = 1'b1;
               end else begin
                  hit       = 1'b1;
                  mem_re    = 1'b1;
                  rd_ptr_in = rd_ptr_inc;
                  fill_in   = fill_ff - 1'b1;
               end
               pull_cnt_in = pull_cnt_ff + 1'b1;
            end
            OP_FLUSH: begin
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Contents of the pending stage and the valid bits.
   always_comb begin
      pend_in.hit        = hit;
      pend_in.underrun   = und_flag;
      pend_in.overrun    = ovr_flag;
      pend_in.depth      = DEPTH_W'(fill_in);
      pend_in.ovr_total  = ovr_cnt_in;
      pend_in.und_total  = und_cnt_in;
      pend_in.push_total = push_cnt_in;
      pend_in.pull_total = pull_cnt_in;
      if (req_fire) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Sample memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_waddr] <= req_if.sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= sample_mem[rd_ptr_ff];
      end
   end

   // Control state and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         ovr_cnt_ff    <= '0;
         und_cnt_ff    <= '0;
         push_cnt_ff   <= '0;
         pull_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         ovr_cnt_ff    <= ovr_cnt_in;
         und_cnt_ff    <= und_cnt_in;
         push_cnt_ff   <= push_cnt_in;
         pull_cnt_ff   <= pull_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers of the pending stage and the response.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_ff <= pend_in;
      end
      if (pend_move) begin
         rsp_ff        <= pend_ff;
         rsp_sample_ff <= pend_ff.hit ? mem_rdata_ff : '0;
      end
   end

   // Response channel outputs.
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.sample_out     = rsp_sample_ff;
   assign rsp_if.underrun       = rsp_ff.underrun;
   assign rsp_if.overrun        = rsp_ff.overrun;
   assign rsp_if.depth          = rsp_ff.depth;
   assign rsp_if.overrun_total  = rsp_ff.ovr_total;
   assign rsp_if.underrun_total = rsp_ff.und_total;
   assign rsp_if.pushed_total   = rsp_ff.push_total;
   assign rsp_if.pulled_total   = rsp_ff.pull_total;

`ifndef SYNTHESIS
   // The fill level never exceeds the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(QUEUE_DEPTH))
      else $error("fill level above capacity");

   // The read pointer stays inside the memory.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= AW'(QUEUE_DEPTH - 1))
      else $error("read pointer outside the memory");

   // A push into a full queue counts exactly one overrun and keeps it full.
   a_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.op == OP_PUSH && full) |=>
         (ovr_cnt_ff == $past(ovr_cnt_ff) + 1'b1) && (fill_ff == CW'(QUEUE_DEPTH)))
      else $error("overrun not handled");

   // Read data held for a waiting pending stage must not be overwritten.
   a_rdata_hold: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !pend_move) |=> $stable(mem_rdata_ff))
      else $error("memory read data lost while pending");
`endif

endmodule

`default_nettype wire
